// File: hw/rtl/ctiu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctiu_pkg;

  // field widths of the request and result items
  localparam int POS_W     = 12;
  localparam int CUR_W     = 16;
  localparam int IDX_W     = 5;
  localparam int CFG_CNT_W = 6;

  // configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // request function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // register word index, taken from paddr[APB_AW-1]
  localparam logic REG_POINTS_IN_USE = 1'b0;

  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [CUR_W-1:0] cur_t;

  localparam cur_t CUR_MAX = 16'sh7FFF;
  localparam cur_t CUR_MIN = 16'sh8000;

  // one table point
  typedef struct packed {
    pos_t pos;
    cur_t cur;
  } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/ctiu_if.sv
`timescale 1ns / 1ps
`default_nettype none

// request channel: load a table point or query a position
interface ctiu_req_if;
  import ctiu_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] entry_index;
  pos_t             entry_position;
  cur_t             entry_current;
  pos_t             query_position;

  modport source (
    output valid, func, entry_index, entry_position, entry_current, query_position,
    input  ready
  );

  modport sink (
    input  valid, func, entry_index, entry_position, entry_current, query_position,
    output ready
  );
endinterface

// result channel: interpolated compensation current
interface ctiu_rsp_if;
  import ctiu_pkg::*;

  logic valid;
  logic ready;
  cur_t comp_current;

  modport source (
    output valid, comp_current,
    input  ready
  );

  modport sink (
    input  valid, comp_current,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/ctiu_table.sv
`timescale 1ns / 1ps
`default_nettype none

module ctiu_table #(
  parameter int DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  ctiu_pkg::entry_t           wr_data,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output ctiu_pkg::entry_t           rd_data
);
  import ctiu_pkg::*;

  entry_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/ctiu_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ctiu_div #(
  parameter int N_W = 31,
  parameter int D_W = 13
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [N_W-1:0] quotient,
  output logic           done
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic [N_W-1:0]   dvd;
  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D_W:0]     shifted;
  logic [D_W:0]     trial;
  logic             take;

  // one restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    shifted = {rem, dvd[N_W-1]};
    trial   = shifted - {1'b0, dsr};
    take    = (shifted >= {1'b0, dsr});
  end

  // one quotient bit per cycle, quotient shifts into the dividend register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == CNT_W'(1));
      if (start) begin
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
        cnt  <= CNT_W'(N_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= take ? trial[D_W-1:0] : shifted[D_W-1:0];
        dvd <= {dvd[N_W-2:0], take};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

// File: hw/rtl/circular_table_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake       payload
// req       in         valid / ready   func, entry_index, entry_position,
//                                      entry_current, query_position
// rsp       out        valid / ready   comp_current
// apb       in         psel / penable  points_in_use at word 0
//
// a load request writes the table in its accept cycle
// a query reads one table point per cycle, then runs one multiply and a restoring
// divide of PROD_W quotient bits, one a cycle; with no points in use the result is
// zero, and with one point it is that point's current, with no multiply or divide
// reset clears the sequencer, the divider, the result valid flag and points_in_use only
// a result waits in the output register; a stalled result holds off the next one

module circular_table_interpolator_unit #(
  parameter int TABLE_DEPTH    = 32,
  parameter int COUNTS_PER_REV = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ctiu_pkg::APB_AW-1:0]   paddr,
  input  logic [ctiu_pkg::APB_DW-1:0]   pwdata,
  output logic [ctiu_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  ctiu_req_if.sink                      req,
  ctiu_rsp_if.source                    rsp
);
  import ctiu_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int NW     = (CW > CFG_CNT_W) ? CW : CFG_CNT_W;
  localparam int IW     = (AW > IDX_W) ? AW : IDX_W;
  localparam int OFF_W  = $clog2(COUNTS_PER_REV + (2 ** POS_W)) + 1;
  localparam int DLT_W  = CUR_W + 1;
  localparam int PROD_W = DLT_W + OFF_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int DSR_W  = OFF_W - 1;

  localparam logic signed [OFF_W-1:0] CPR_S  = OFF_W'(COUNTS_PER_REV);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(CUR_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(CUR_MIN);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_WRAP,
    S_MUL,
    S_DIV_GO,
    S_DIV_WAIT,
    S_PUSH
  } state_t;

  state_t                     state;
  logic [CFG_CNT_W-1:0]       points_in_use;
  pos_t                       q_r;
  logic [NW-1:0]              n_last_r;
  logic [AW-1:0]              k_r;
  entry_t                     first_r;
  entry_t                     prev_r;
  cur_t                       left_r;
  logic signed [DLT_W-1:0]    delta_r;
  logic signed [OFF_W-1:0]    off_r;
  logic signed [OFF_W-1:0]    span_r;
  logic signed [PROD_W-1:0]   prod_r;
  cur_t                       res_r;
  logic                       out_valid_r;
  cur_t                       out_cur_r;

  logic                       cfg_wr;
  logic [NW-1:0]              n_ext;
  logic [NW-1:0]              n_eff;
  logic [IW-1:0]              idx_ext;
  logic                       tbl_wr_en;
  logic [AW-1:0]              rd_addr;
  entry_t                     rd_data;

  logic signed [OFF_W-1:0]    q_s;
  logic signed [OFF_W-1:0]    rd_pos_s;
  logic signed [OFF_W-1:0]    prev_pos_s;
  logic signed [OFF_W-1:0]    first_pos_s;
  logic                       inner_hit;
  logic                       is_last;
  logic signed [DLT_W-1:0]    inner_delta;
  logic                       wrap_hit;
  logic signed [OFF_W-1:0]    qe_s;
  logic signed [OFF_W-1:0]    wrap_off;
  logic signed [OFF_W-1:0]    wrap_span;
  logic                       span_pos;
  logic signed [DLT_W-1:0]    wrap_delta;

  logic                       div_start;
  logic                       div_done;
  logic [PROD_W-1:0]          div_mag;
  logic [PROD_W-1:0]          quo;
  logic signed [PROD_W:0]     frac;
  logic signed [SUM_W-1:0]    sum;
  cur_t                       sat;

  // configuration register, byte offset bits ignored
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= '0;
    end else if (cfg_wr && (paddr[APB_AW-1] == REG_POINTS_IN_USE)) begin
      points_in_use <= pwdata[CFG_CNT_W-1:0];
    end
  end

  assign prdata = (paddr[APB_AW-1] == REG_POINTS_IN_USE) ? APB_DW'(points_in_use) : '0;

  // point count limited to the table depth
  always_comb begin
    n_ext = NW'(points_in_use);
    n_eff = (n_ext > NW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : n_ext;
  end

  // table write on a load request, out-of-range slots dropped
  assign idx_ext   = IW'(req.entry_index);
  assign tbl_wr_en = (state == S_IDLE) && req.valid && (req.func == FUNC_LOAD) &&
                     (int'(req.entry_index) < TABLE_DEPTH);

  // read address: slot 0 while idle, then one slot ahead of the scan
  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = k_r + AW'(1);
    end else if (state == S_FIRST) begin
      rd_addr = AW'(1);
    end else begin
      rd_addr = '0;
    end
  end

  ctiu_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (idx_ext[AW-1:0]),
    .wr_data ({req.entry_position, req.entry_current}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // inner segment test between the previous point and the one just read
  always_comb begin
    q_s         = $signed({{(OFF_W-POS_W){1'b0}}, q_r});
    rd_pos_s    = $signed({{(OFF_W-POS_W){1'b0}}, rd_data.pos});
    prev_pos_s  = $signed({{(OFF_W-POS_W){1'b0}}, prev_r.pos});
    first_pos_s = $signed({{(OFF_W-POS_W){1'b0}}, first_r.pos});
    inner_hit   = (q_r >= prev_r.pos) && (q_r < rd_data.pos);
    is_last     = (NW'(k_r) == n_last_r);
    inner_delta = $signed({rd_data.cur[CUR_W-1], rd_data.cur}) -
                  $signed({prev_r.cur[CUR_W-1], prev_r.cur});
  end

  // wrap segment from the last point back to slot 0
  always_comb begin
    wrap_hit   = (q_r >= prev_r.pos) || (q_r < first_r.pos);
    qe_s       = (q_r < first_r.pos) ? (q_s + CPR_S) : q_s;
    wrap_off   = qe_s - prev_pos_s;
    wrap_span  = first_pos_s + CPR_S - prev_pos_s;
    span_pos   = !wrap_span[OFF_W-1] && (wrap_span != '0);
    wrap_delta = $signed({first_r.cur[CUR_W-1], first_r.cur}) -
                 $signed({prev_r.cur[CUR_W-1], prev_r.cur});
  end

  // divider on magnitudes, sign restored afterwards
  assign div_start = (state == S_DIV_GO);
  assign div_mag   = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);

  ctiu_div #(
    .N_W (PROD_W),
    .D_W (DSR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (span_r[DSR_W-1:0]),
    .quotient (quo),
    .done     (div_done)
  );

  // left point plus truncated fraction, saturated to the current range
  always_comb begin
    frac = prod_r[PROD_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    sum  = $signed({{(SUM_W-CUR_W){left_r[CUR_W-1]}}, left_r}) + $signed({frac[PROD_W], frac});
    if (sum > SAT_HI) begin
      sat = CUR_MAX;
    end else if (sum < SAT_LO) begin
      sat = CUR_MIN;
    end else begin
      sat = sum[CUR_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && rsp.ready && (state != S_PUSH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && (req.func == FUNC_QUERY)) begin
            q_r      <= req.query_position;
            n_last_r <= n_eff - NW'(1);
            if (n_eff == '0) begin
              res_r <= '0;
              state <= S_PUSH;
            end else begin
              state <= S_FIRST;
            end
          end
        end
        S_FIRST: begin
          first_r <= rd_data;
          prev_r  <= rd_data;
          k_r     <= AW'(1);
          if (n_last_r == '0) begin
            res_r <= rd_data.cur;
            state <= S_PUSH;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (inner_hit) begin
            left_r  <= prev_r.cur;
            delta_r <= inner_delta;
            off_r   <= q_s - prev_pos_s;
            span_r  <= rd_pos_s - prev_pos_s;
            state   <= S_MUL;
          end else begin
            prev_r <= rd_data;
            k_r    <= k_r + AW'(1);
            if (is_last) begin
              state <= S_WRAP;
            end
          end
        end
        S_WRAP: begin
          if (!wrap_hit) begin
            res_r <= '0;
            state <= S_PUSH;
          end else if (!span_pos) begin
            res_r <= prev_r.cur;
            state <= S_PUSH;
          end else begin
            left_r  <= prev_r.cur;
            delta_r <= wrap_delta;
            off_r   <= wrap_off;
            span_r  <= wrap_span;
            state   <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r <= delta_r * off_r;
          state  <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            res_r <= sat;
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!out_valid_r || rsp.ready) begin
            out_valid_r <= 1'b1;
            out_cur_r   <= res_r;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid_r;
  assign rsp.comp_current = out_cur_r;

endmodule

`default_nettype wire

// File: hw/rtl/ctiu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ctiu_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           req_func,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input ctiu_pkg::cur_t comp_current
);
  import ctiu_pkg::*;

  logic       query_fire;
  logic       load_fire;
  logic       rsp_fire;
  logic [1:0] pending;

  assign query_fire = req_valid && req_ready && (req_func == FUNC_QUERY);
  assign load_fire  = req_valid && req_ready && (req_func == FUNC_LOAD);
  assign rsp_fire   = rsp_valid && rsp_ready;

  // queries accepted and not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (query_fire && !rsp_fire) begin
      pending <= pending + 2'd1;
    end else if (!query_fire && rsp_fire) begin
      pending <= pending - 2'd1;
    end
  end

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(comp_current))
    else $error("stalled result changed or dropped");

  // a query keeps the block busy in the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    query_fire |=> !req_ready)
    else $error("request accepted right after a query");

  // a load leaves the block ready again
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> req_ready)
    else $error("block not ready after a load");

  // every result belongs to an accepted query
  a_rsp_owned: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pending != 2'd0))
    else $error("result without a query");

  // at most one query in work and one result waiting
  a_depth: assert property (@(posedge clk) disable iff (rst)
    query_fire |-> (pending != 2'd2) && (pending != 2'd3))
    else $error("too many queries outstanding");

endmodule

bind circular_table_interpolator_unit ctiu_checker u_ctiu_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_func     (req.func),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .comp_current (rsp.comp_current)
);

`default_nettype wire
